// File: rtl/core/apest_pkg.sv
// ----------------------------------------------------------------------------
// apest_pkg
// Shared types and constants for the address pair event suppress table.
// ----------------------------------------------------------------------------
package apest_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam int ROW_W = 32 + 32 + 32 + 16;

    localparam logic [1:0] FUNC_CHECK = 2'd0;
    localparam logic [1:0] FUNC_PRUNE = 2'd1;
    localparam logic [1:0] FUNC_FLUSH = 2'd2;

    localparam logic [1:0] REG_SUPPRESS_WINDOW = 2'd0;
    localparam logic [1:0] REG_RETIRE_AGE      = 2'd1;
    localparam logic [1:0] REG_PRUNE_INTERVAL  = 2'd2;

    localparam logic [15:0] SUPPRESS_WINDOW_RST = 16'd60;
    localparam logic [15:0] RETIRE_AGE_RST      = 16'd300;
    localparam logic [15:0] PRUNE_INTERVAL_RST  = 16'd10;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [31:0] now;
    } req_t;

    typedef struct packed {
        logic        suppress;
        logic [15:0] hit_count;
        logic        status;
        logic        record_valid;
        logic [31:0] rec_src;
        logic [31:0] rec_dst;
        logic [31:0] rec_time;
        logic [15:0] rec_count;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic [31:0] src;
        logic [31:0] dst;
        logic [31:0] tstamp;
        logic [15:0] count;
    } row_t;
endpackage

// File: rtl/core/apest_if.sv
// ----------------------------------------------------------------------------
// apest_req_if / apest_rsp_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
interface apest_req_if;
    logic            valid;
    logic            ready;
    apest_pkg::req_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface apest_rsp_if;
    logic            valid;
    logic            ready;
    apest_pkg::rsp_t payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: rtl/core/apest_ram.sv
// ----------------------------------------------------------------------------
// apest_ram
// Generic single-port synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module apest_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// File: rtl/core/address_pair_event_suppress_table.sv
// ----------------------------------------------------------------------------
// address_pair_event_suppress_table
// Windowed event counter table keyed by address pair, with prune and flush.
// ----------------------------------------------------------------------------
// A check, an effective prune or a flush reads every row (ST_RD) and evaluates it
// (ST_EVAL); a check loads its result in ST_DONE, a prune or flush its last record
// in ST_WAIT, or its result in ST_DONE if none is evicted; output stalls delay loads.
// A prune tick before its interval or an unused func goes straight to ST_DONE.
// One request at a time: the next is taken the cycle after the last result loads.
// Reset: table empty (valid flops cleared), registers at defaults, no clearing pass.
module address_pair_event_suppress_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    apest_req_if.sink   req,
    apest_rsp_if.source rsp
);
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_RD   = 3'd1;
    localparam logic [2:0] ST_EVAL = 3'd2;
    localparam logic [2:0] ST_WAIT = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [15:0] win_reg, age_reg, intv_reg;
    logic [31:0] lpt_reg;
    logic [apest_pkg::TABLE_DEPTH-1:0] valid_reg;
    logic [2:0] state_reg;
    apest_pkg::req_t cur_reg;
    logic [apest_pkg::CNT_W-1:0] idx_reg;
    logic hit_reg, free_reg, evicted_reg;
    logic [apest_pkg::IDX_W-1:0] hit_idx_reg, free_idx_reg;
    apest_pkg::row_t hit_row_reg;
    apest_pkg::row_t pend_reg;
    logic out_valid_reg;
    apest_pkg::rsp_t out_reg;

    logic ram_we;
    logic [apest_pkg::IDX_W-1:0] ram_addr;
    apest_pkg::row_t ram_wdata, ram_rdata;

    apest_ram #(.WIDTH(apest_pkg::ROW_W), .DEPTH(apest_pkg::TABLE_DEPTH)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
    );

    logic [apest_pkg::IDX_W-1:0] cidx;
    logic cvalid, match, expire, win_exp;
    logic [15:0] inc;
    logic cfg_wr;
    logic out_free, scan_end, load_out;
    apest_pkg::rsp_t empty_rsp;
    apest_pkg::rsp_t out_next;

    assign cidx    = idx_reg[apest_pkg::IDX_W-1:0];
    assign cvalid  = valid_reg[cidx];
    assign match   = (ram_rdata.src == cur_reg.src_addr) && (ram_rdata.dst == cur_reg.dst_addr);
    assign expire  = (cur_reg.func == apest_pkg::FUNC_FLUSH) ||
                     ({1'b0, cur_reg.now} > ({1'b0, ram_rdata.tstamp} + {17'd0, age_reg}));
    assign inc     = (hit_row_reg.count == 16'hFFFF) ? 16'hFFFF : hit_row_reg.count + 16'd1;
    assign win_exp = ({1'b0, hit_row_reg.tstamp} + {17'd0, win_reg}) <= {1'b0, cur_reg.now};
    assign cfg_wr  = psel && penable && pwrite;
    assign out_free = !out_valid_reg || rsp.ready;
    assign scan_end = (idx_reg == apest_pkg::CNT_W'(apest_pkg::TABLE_DEPTH - 1));
    assign pready  = 1'b1;
    assign req.ready = (state_reg == ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.payload = out_reg;

    always_comb
    begin
        empty_rsp = '0;
        empty_rsp.last = 1'b1;
        case (paddr[3:2])
            apest_pkg::REG_SUPPRESS_WINDOW: prdata = {16'd0, win_reg};
            apest_pkg::REG_RETIRE_AGE:      prdata = {16'd0, age_reg};
            apest_pkg::REG_PRUNE_INTERVAL:  prdata = {16'd0, intv_reg};
            default:                        prdata = 32'd0;
        endcase
        ram_we = 1'b0;
        ram_addr = cidx;
        ram_wdata = hit_row_reg;
        if (state_reg == ST_DONE && cur_reg.func == apest_pkg::FUNC_CHECK)
        begin
            if (hit_reg)
            begin
                ram_we = 1'b1;
                ram_addr = hit_idx_reg;
                ram_wdata.count = win_exp ? 16'd0 : inc;
                ram_wdata.tstamp = win_exp ? cur_reg.now : hit_row_reg.tstamp;
            end
            else if (free_reg)
            begin
                ram_we = 1'b1;
                ram_addr = free_idx_reg;
                ram_wdata = '{src: cur_reg.src_addr, dst: cur_reg.dst_addr,
                              tstamp: cur_reg.now, count: 16'd1};
            end
        end

        load_out = 1'b0;
        out_next = empty_rsp;
        case (state_reg)
            ST_EVAL:
            begin
                if (cur_reg.func != apest_pkg::FUNC_CHECK && cvalid && expire &&
                    evicted_reg && out_free)
                begin
                    load_out = 1'b1;
                    out_next.record_valid = 1'b1;
                    out_next.rec_src = pend_reg.src;
                    out_next.rec_dst = pend_reg.dst;
                    out_next.rec_time = pend_reg.tstamp;
                    out_next.rec_count = pend_reg.count;
                    out_next.last = 1'b0;
                end
            end
            ST_WAIT:
            begin
                if (evicted_reg && out_free)
                begin
                    load_out = 1'b1;
                    out_next.record_valid = 1'b1;
                    out_next.rec_src = pend_reg.src;
                    out_next.rec_dst = pend_reg.dst;
                    out_next.rec_time = pend_reg.tstamp;
                    out_next.rec_count = pend_reg.count;
                    out_next.last = 1'b1;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    load_out = 1'b1;
                    if (cur_reg.func == apest_pkg::FUNC_CHECK)
                    begin
                        out_next.hit_count = hit_reg ? inc : 16'd1;
                        out_next.suppress = hit_reg && !win_exp;
                        out_next.status = !hit_reg && !free_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= apest_pkg::SUPPRESS_WINDOW_RST;
            age_reg <= apest_pkg::RETIRE_AGE_RST;
            intv_reg <= apest_pkg::PRUNE_INTERVAL_RST;
            lpt_reg <= '0;
            valid_reg <= '0;
            state_reg <= ST_IDLE;
            cur_reg <= '0;
            out_valid_reg <= 1'b0;
            out_reg <= '0;
            idx_reg <= '0;
            hit_reg <= 1'b0;
            free_reg <= 1'b0;
            evicted_reg <= 1'b0;
            hit_idx_reg <= '0;
            free_idx_reg <= '0;
            hit_row_reg <= '0;
            pend_reg <= '0;
        end
        else
        begin
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
                out_reg <= out_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr)
            begin
                case (paddr[3:2])
                    apest_pkg::REG_SUPPRESS_WINDOW: win_reg <= pwdata[15:0];
                    apest_pkg::REG_RETIRE_AGE:      age_reg <= pwdata[15:0];
                    apest_pkg::REG_PRUNE_INTERVAL:  intv_reg <= pwdata[15:0];
                    default: ;
                endcase
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (req.valid)
                    begin
                        cur_reg <= req.payload;
                        idx_reg <= '0;
                        hit_reg <= 1'b0;
                        free_reg <= 1'b0;
                        evicted_reg <= 1'b0;
                        if (req.payload.func == apest_pkg::FUNC_CHECK ||
                            req.payload.func == apest_pkg::FUNC_FLUSH)
                        begin
                            state_reg <= ST_RD;
                        end
                        else if (req.payload.func == apest_pkg::FUNC_PRUNE &&
                                 ({1'b0, lpt_reg} + {17'd0, intv_reg}) <
                                 {1'b0, req.payload.now})
                        begin
                            lpt_reg <= req.payload.now;
                            state_reg <= ST_RD;
                        end
                        else
                        begin
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_RD:
                begin
                    state_reg <= ST_EVAL;
                end
                ST_EVAL:
                begin
                    if (cur_reg.func == apest_pkg::FUNC_CHECK)
                    begin
                        if (cvalid && match && !hit_reg)
                        begin
                            hit_reg <= 1'b1;
                            hit_idx_reg <= cidx;
                            hit_row_reg <= ram_rdata;
                        end
                        if (!cvalid && !free_reg)
                        begin
                            free_reg <= 1'b1;
                            free_idx_reg <= cidx;
                        end
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= scan_end ? ST_DONE : ST_RD;
                    end
                    else if (cvalid && expire)
                    begin
                        // records leave one step late so the final one carries last
                        if (!evicted_reg || out_free)
                        begin
                            pend_reg <= ram_rdata;
                            valid_reg[cidx] <= 1'b0;
                            evicted_reg <= 1'b1;
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= scan_end ? ST_WAIT : ST_RD;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= scan_end ? ST_WAIT : ST_RD;
                    end
                end
                ST_WAIT:
                begin
                    if (!evicted_reg)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        if (cur_reg.func == apest_pkg::FUNC_CHECK && !hit_reg && free_reg)
                        begin
                            valid_reg[free_idx_reg] <= 1'b1;
                        end
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    property p_busy_no_ready;
        @(posedge clk) disable iff (!rst_n) (state_reg != ST_IDLE) |-> !req.ready;
    endproperty
    a_busy_no_ready: assert property (p_busy_no_ready) else $error("ready while busy");

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
            (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp.payload));
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result changed while stalled");
endmodule
